// ----- hw/rtl/lffa_pkg.sv -----
// Shared types, codes and default sizes of the liveness first-fit allocator.
package lffa_pkg;

   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_ADDR_BITS   = 32;
   localparam int DEF_STEP_BITS   = 16;

   // Fixed widths of the request and response ports.
   localparam int STEP_PORT_BITS  = 16;
   localparam int BYTES_PORT_BITS = 32;
   localparam int OUT_ADDR_BITS   = 32;
   localparam int STATUS_BITS     = 2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_PLACED,
      STATUS_FULL,
      STATUS_OVERFLOW
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_INSERT,
      ST_RESPOND
   } state_type;

   // Verdict of the compare unit on one table entry.
   typedef struct packed {
      logic relevant;   // live intervals overlap
      logic stop;       // candidate range does not collide with the entry
      logic above;      // entry starts above the candidate
      logic end_ok;     // candidate end stays inside the address range
   } scan_flags_type;

endpackage

// ----- hw/rtl/lffa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lffa_scan_unit.sv -----
// Shared compare and add unit: judges one table entry against the candidate.
module lffa_scan_unit #(
   parameter int ADDR_BITS = lffa_pkg::DEF_ADDR_BITS,
   parameter int STEP_BITS = lffa_pkg::DEF_STEP_BITS,
   parameter int SUM_BITS  = lffa_pkg::DEF_ADDR_BITS + 1
) (
   input  logic [ADDR_BITS-1:0]                 ent_start,
   input  logic [ADDR_BITS-1:0]                 ent_end,
   input  logic [STEP_BITS-1:0]                 ent_first,
   input  logic [STEP_BITS-1:0]                 ent_final,
   input  logic [STEP_BITS-1:0]                 req_first,
   input  logic [STEP_BITS-1:0]                 req_final,
   input  logic [lffa_pkg::BYTES_PORT_BITS-1:0] req_bytes,
   input  logic [ADDR_BITS-1:0]                 cand,
   input  logic [SUM_BITS-1:0]                  cand_sum,
   output logic [SUM_BITS-1:0]                  next_sum,
   output lffa_pkg::scan_flags_type             flags
);
   import lffa_pkg::*;

   localparam logic [SUM_BITS-1:0] ADDR_MAX = SUM_BITS'({ADDR_BITS{1'b1}});

   logic end_ok;

   always_comb begin
      end_ok         = (cand_sum <= ADDR_MAX);
      flags.end_ok   = end_ok;
      flags.relevant = (ent_first <= req_final) && (req_first <= ent_final);
      flags.stop     = (ent_end <= cand) || (end_ok && (cand_sum <= SUM_BITS'(ent_start)));
      flags.above    = (ent_start > cand);
      // candidate end if the candidate moves past this entry
      next_sum       = SUM_BITS'(ent_end) + SUM_BITS'(req_bytes);
   end

endmodule

// ----- hw/rtl/liveness_first_fit_allocator.sv -----
// Top level of the liveness first-fit allocator: sequencer, table and result registers.
//
//  - Request channel: drive req_* and raise start; the request is taken at the
//    rising edge where start is high and busy is low. busy stays high until
//    the response has been shown.
//  - Response channel: rsp_valid is high for exactly one cycle with
//    rsp_placed_address, rsp_peak_bytes and rsp_status. The receiver cannot
//    stall; it must take the response in that cycle.
//  - req_new_set drops the whole table and the peak before the request is placed.
//  - Steps: take the request, scan the table at one entry per cycle (the scan
//    can stop early), make the decision, run an insertion pass that moves the
//    entries above the new one up by one slot (skipped when the table is full
//    or the address range overflows) and show the response.
//  - Throughput: one request at a time; the next may start the cycle after
//    the response.
//  - Reset empties the table and clears the peak at once; table contents are
//    never read beyond the entry count, so no clearing pass is needed.
module liveness_first_fit_allocator #(
   parameter int MAX_ENTRIES = lffa_pkg::DEF_MAX_ENTRIES,
   parameter int ADDR_BITS   = lffa_pkg::DEF_ADDR_BITS,
   parameter int STEP_BITS   = lffa_pkg::DEF_STEP_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_new_set,
   input  logic [lffa_pkg::STEP_PORT_BITS-1:0]  req_live_first,
   input  logic [lffa_pkg::STEP_PORT_BITS-1:0]  req_live_final,
   input  logic [lffa_pkg::BYTES_PORT_BITS-1:0] req_request_bytes,
   output logic                                 rsp_valid,
   output logic [lffa_pkg::OUT_ADDR_BITS-1:0]   rsp_placed_address,
   output logic [lffa_pkg::OUT_ADDR_BITS-1:0]   rsp_peak_bytes,
   output logic [lffa_pkg::STATUS_BITS-1:0]     rsp_status
);
   import lffa_pkg::*;

   localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
   localparam int WIDE_BITS  = (ADDR_BITS > BYTES_PORT_BITS) ? ADDR_BITS : BYTES_PORT_BITS;
   localparam int SUM_BITS   = WIDE_BITS + 1;
   // table word: start, end, first step, final step
   localparam int ENTRY_BITS = 2 * ADDR_BITS + 2 * STEP_BITS;

   // sequencer and result state
   state_type                  state_ff, state_in;
   logic [CNT_BITS-1:0]        idx_ff, idx_in;
   logic                       pend_ff, pend_in;
   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic [ADDR_BITS-1:0]       peak_ff, peak_in;
   logic [ADDR_BITS-1:0]       cand_ff, cand_in;
   logic [SUM_BITS-1:0]        cand_sum_ff, cand_sum_in;
   logic [BYTES_PORT_BITS-1:0] bytes_ff, bytes_in;
   logic [STEP_BITS-1:0]       first_ff, first_in;
   logic [STEP_BITS-1:0]       final_ff, final_in;
   status_type                 status_ff, status_in;

   // table port
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ENTRY_BITS-1:0] new_entry;

   logic [ADDR_BITS-1:0]  ent_start;
   logic [ADDR_BITS-1:0]  ent_end;
   logic [STEP_BITS-1:0]  ent_first;
   logic [STEP_BITS-1:0]  ent_final;
   logic [SUM_BITS-1:0]   next_sum;
   scan_flags_type        flags;
   logic                  issue;
   logic [CNT_BITS-1:0]   slot_down;

   lffa_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_start = rd_data[ENTRY_BITS-1 -: ADDR_BITS];
   assign ent_end   = rd_data[2*STEP_BITS+ADDR_BITS-1 -: ADDR_BITS];
   assign ent_first = rd_data[2*STEP_BITS-1 -: STEP_BITS];
   assign ent_final = rd_data[STEP_BITS-1:0];
   assign new_entry = {cand_ff, cand_sum_ff[ADDR_BITS-1:0], first_ff, final_ff};

   lffa_scan_unit #(
      .ADDR_BITS (ADDR_BITS),
      .STEP_BITS (STEP_BITS),
      .SUM_BITS  (SUM_BITS)
   ) u_scan (
      .ent_start (ent_start),
      .ent_end   (ent_end),
      .ent_first (ent_first),
      .ent_final (ent_final),
      .req_first (first_ff),
      .req_final (final_ff),
      .req_bytes (bytes_ff),
      .cand      (cand_ff),
      .cand_sum  (cand_sum_ff),
      .next_sum  (next_sum),
      .flags     (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         peak_ff  <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      cand_sum_ff <= cand_sum_in;
      bytes_ff    <= bytes_in;
      first_ff    <= first_in;
      final_ff    <= final_in;
      status_ff   <= status_in;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      count_in    = count_ff;
      peak_in     = peak_ff;
      cand_in     = cand_ff;
      cand_sum_in = cand_sum_ff;
      bytes_in    = bytes_ff;
      first_in    = first_ff;
      final_in    = final_ff;
      status_in   = status_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = new_entry;
      issue       = 1'b0;
      slot_down   = idx_ff - CNT_BITS'(1);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // take the request; a new set drops the table and the peak
               if (req_new_set) begin
                  count_in = '0;
                  peak_in  = '0;
               end
               bytes_in    = req_request_bytes;
               first_in    = STEP_BITS'(req_live_first);
               final_in    = STEP_BITS'(req_live_final);
               cand_in     = '0;
               cand_sum_in = SUM_BITS'(req_request_bytes);
               idx_in      = '0;
               pend_in     = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle, judge the entry read the cycle before
            issue   = (idx_ff < count_ff);
            pend_in = issue;
            if (issue) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[IDX_BITS-1:0];
               idx_in  = idx_ff + CNT_BITS'(1);
            end
            if (pend_ff && flags.relevant) begin
               if (flags.stop) begin
                  pend_in  = 1'b0;
                  state_in = ST_PLACE;
               end else begin
                  // collision: move the candidate to the end of this entry
                  cand_in     = ent_end;
                  cand_sum_in = next_sum;
               end
            end else if (!pend_ff && !issue) begin
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            idx_in  = count_ff;
            pend_in = 1'b0;
            if (count_ff == CNT_BITS'(MAX_ENTRIES)) begin
               status_in = STATUS_FULL;
               state_in  = ST_RESPOND;
            end else if (!flags.end_ok) begin
               status_in = STATUS_OVERFLOW;
               state_in  = ST_RESPOND;
            end else begin
               status_in = STATUS_PLACED;
               state_in  = ST_INSERT;
            end
         end

         ST_INSERT: begin
            // walk down from the top, moving entries that start above the candidate
            if (!pend_ff) begin
               if (idx_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = new_entry;
                  count_in = count_ff + CNT_BITS'(1);
                  if (cand_sum_ff > SUM_BITS'(peak_ff)) begin
                     peak_in = cand_sum_ff[ADDR_BITS-1:0];
                  end
                  state_in = ST_RESPOND;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_down[IDX_BITS-1:0];
                  pend_in = 1'b1;
               end
            end else if (flags.above) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[IDX_BITS-1:0];
               wr_data = rd_data;
               idx_in  = slot_down;
               if (slot_down == '0) begin
                  pend_in = 1'b0;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_BITS'(slot_down - CNT_BITS'(1));
                  pend_in = 1'b1;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff[IDX_BITS-1:0];
               wr_data  = new_entry;
               pend_in  = 1'b0;
               count_in = count_ff + CNT_BITS'(1);
               if (cand_sum_ff > SUM_BITS'(peak_ff)) begin
                  peak_in = cand_sum_ff[ADDR_BITS-1:0];
               end
               state_in = ST_RESPOND;
            end
         end

         ST_RESPOND: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_RESPOND);
   assign rsp_placed_address = OUT_ADDR_BITS'(cand_ff);
   assign rsp_peak_bytes     = OUT_ADDR_BITS'(peak_ff);
   assign rsp_status         = status_ff;

endmodule

// ----- hw/rtl/lffa_checker.sv -----
// Port-level checker for the liveness first-fit allocator, bound to the top level.
module lffa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [lffa_pkg::STATUS_BITS-1:0] rsp_status
);
   import lffa_pkg::*;

   // a taken request makes the block busy
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("request taken but block not busy");

   // a response only appears while a request is in work
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("response outside a request");

   // one response per request, then the block is free again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid && !busy)
      else $error("response not a single pulse");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_PLACED) || (rsp_status == STATUS_FULL) ||
                    (rsp_status == STATUS_OVERFLOW))
      else $error("undefined status code");

endmodule

bind liveness_first_fit_allocator lffa_checker u_lffa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);

// ----- tb/liveness_first_fit_allocator_test.sv -----
// Self-checking testbench for the allocator: directed corners, full table, back-to-back, random sets.
module liveness_first_fit_allocator_test;
   import lffa_pkg::*;

   localparam int TABLE_DEPTH   = DEF_MAX_ENTRIES;
   localparam logic [63:0] LAST_ADDRESS = (64'd1 << DEF_ADDR_BITS) - 64'd1;
   localparam int TOTAL_REQUESTS = 1350;
   localparam int QUIET_LIMIT   = 3000;   // cycles with no request and no response taken
   localparam int SETTLE_CYCLES = 8;

   // One expected response.
   typedef struct {
      logic [OUT_ADDR_BITS-1:0] placed_address;
      logic [OUT_ADDR_BITS-1:0] peak_bytes;
      status_type               status;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_new_set = 1'b0;
   logic [STEP_PORT_BITS-1:0]  req_live_first = '0;
   logic [STEP_PORT_BITS-1:0]  req_live_final = '0;
   logic [BYTES_PORT_BITS-1:0] req_request_bytes = '0;
   logic rsp_valid;
   logic [OUT_ADDR_BITS-1:0] rsp_placed_address;
   logic [OUT_ADDR_BITS-1:0] rsp_peak_bytes;
   logic [STATUS_BITS-1:0]   rsp_status;

   // Mirror of the allocation table, kept in ascending start order.
   logic [63:0] buf_start [TABLE_DEPTH];
   logic [63:0] buf_size  [TABLE_DEPTH];
   logic [STEP_PORT_BITS-1:0] buf_first [TABLE_DEPTH];
   logic [STEP_PORT_BITS-1:0] buf_last  [TABLE_DEPTH];
   int          buf_count = 0;
   logic [63:0] set_peak  = '0;

   placement_type pending_placements[$];
   int mismatch_count = 0;
   int requests_sent  = 0;
   int max_gap        = 6;
   int quiet_cycles   = 0;

   liveness_first_fit_allocator u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_new_set        (req_new_set),
      .req_live_first     (req_live_first),
      .req_live_final     (req_live_final),
      .req_request_bytes  (req_request_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_placed_address (rsp_placed_address),
      .rsp_peak_bytes     (rsp_peak_bytes),
      .rsp_status         (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Place one buffer in the mirror table and return the response it must produce.
   function automatic placement_type place_buffer(input bit clear_first,
                                                  input logic [15:0] first_step,
                                                  input logic [15:0] last_step,
                                                  input logic [31:0] nbytes);
      placement_type result;
      logic [63:0] cand;
      logic [63:0] size;
      logic [63:0] entry_end;
      logic [63:0] cand_end;
      bit          fits;
      int          slot;
      cand = '0;
      size = {32'd0, nbytes};
      if (clear_first) begin
         buf_count = 0;
         set_peak  = '0;
      end
      // Walk the live-overlapping entries in address order; move past each collision.
      for (int i = 0; i < buf_count; i++) begin
         if (!(buf_first[i] <= last_step && first_step <= buf_last[i]))
            continue;
         entry_end = buf_start[i] + buf_size[i];
         fits      = size <= LAST_ADDRESS - cand;
         cand_end  = fits ? cand + size : '0;
         // An end past the address range sits above every start.
         if (entry_end <= cand || (fits && cand_end <= buf_start[i]))
            break;
         cand = entry_end;
      end
      fits     = size <= LAST_ADDRESS - cand;
      cand_end = fits ? cand + size : '0;
      if (buf_count >= TABLE_DEPTH) begin
         result.status = STATUS_FULL;
      end else if (!fits) begin
         result.status = STATUS_OVERFLOW;
      end else begin
         result.status = STATUS_PLACED;
         // Insert after every entry with start <= cand, so ties keep arrival order.
         slot = 0;
         while (slot < buf_count && buf_start[slot] <= cand)
            slot++;
         for (int i = buf_count; i > slot; i--) begin
            buf_start[i] = buf_start[i-1];
            buf_size[i]  = buf_size[i-1];
            buf_first[i] = buf_first[i-1];
            buf_last[i]  = buf_last[i-1];
         end
         buf_start[slot] = cand;
         buf_size[slot]  = size;
         buf_first[slot] = first_step;
         buf_last[slot]  = last_step;
         buf_count++;
         if (cand_end > set_peak)
            set_peak = cand_end;
      end
      result.placed_address = cand[31:0];
      result.peak_bytes     = set_peak[31:0];
      return result;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   // Present one request after a random gap, hold it until the block takes it,
   // then queue the response it must produce. Called and returns at a rising edge.
   task automatic send_request(input bit clear_first, input logic [15:0] first_step,
                               input logic [15:0] last_step, input logic [31:0] nbytes);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // A zero gap keeps start high: exactly one assignment to start in this step.
      start             <= 1'b1;
      req_new_set       <= clear_first;
      req_live_first    <= first_step;
      req_live_final    <= last_step;
      req_request_bytes <= nbytes;
      do
         @(posedge clock);
      while (busy);
      pending_placements.insert(pending_placements.size(),
                                place_buffer(clear_first, first_step, last_step, nbytes));
      requests_sent++;
   endtask

   // Drop start and hold off until every response is back.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_placements.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly small sizes so tables fill; some zero, some huge, some at the top of the range.
   function automatic logic [31:0] pick_bytes();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 6)
         return 32'd0;
      else if (k < 56)
         return $urandom_range(1, 256);
      else if (k < 76)
         return $urandom_range(1, 65536);
      else if (k < 91)
         return $urandom();
      else
         return 32'hFFFF_FFFF - $urandom_range(0, 4096);
   endfunction

   // Mostly short windows near zero so intervals overlap; also wide, equal and inverted ones.
   function automatic void pick_steps(output logic [15:0] first_step,
                                      output logic [15:0] last_step);
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 60) begin
         first_step = 16'($urandom_range(0, 40));
         last_step  = 16'(first_step + $urandom_range(0, 20));
      end else if (k < 80) begin
         first_step = 16'($urandom());
         last_step  = 16'($urandom());
      end else if (k < 90) begin
         first_step = 16'($urandom());
         last_step  = first_step;
      end else begin
         first_step = 16'($urandom_range(1, 65535));
         last_step  = 16'($urandom_range(0, first_step - 1));
      end
   endfunction

   // Corners: empty table without a clear, zero size, full-range size, overflow,
   // scan that stops on an entry below the candidate, inverted intervals.
   task automatic test_directed_corners();
      send_request(1'b0, 16'd0,     16'd0,     32'd0);
      send_request(1'b1, 16'd0,     16'hFFFF,  32'hFFFF_FFFF);
      send_request(1'b0, 16'd0,     16'hFFFF,  32'd1);
      send_request(1'b0, 16'hFFFF,  16'hFFFF,  32'd0);
      send_request(1'b0, 16'd100,   16'd5,     32'd1);
      send_request(1'b1, 16'd10,    16'd20,    32'd100);
      send_request(1'b0, 16'd10,    16'd20,    32'd50);
      send_request(1'b0, 16'd21,    16'd30,    32'd70);
      send_request(1'b0, 16'd15,    16'd25,    32'd30);
      send_request(1'b0, 16'd20,    16'd21,    32'd0);
      send_request(1'b0, 16'd30,    16'd10,    32'd8);
      send_request(1'b0, 16'd0,     16'hFFFF,  32'h8000_0000);
      send_request(1'b0, 16'd0,     16'hFFFF,  32'h8000_0000);
      send_request(1'b1, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF);
      send_request(1'b0, 16'hFFFF,  16'd0,     32'hFFFF_FFFF);
      send_request(1'b0, 16'd0,     16'd0,     32'd1);
      wait_for_drain();
   endtask

   // Fill every slot with buffers that are all live together, then hit the full table,
   // once with a size that would also overflow, and clear again.
   task automatic test_table_full();
      send_request(1'b1, 16'd0, 16'hFFFF, $urandom_range(1, 4096));
      for (int i = 1; i < TABLE_DEPTH; i++)
         send_request(1'b0, 16'd0, 16'hFFFF, $urandom_range(0, 4096));
      send_request(1'b0, 16'd0,   16'hFFFF, 32'hFFFF_FFFF);
      send_request(1'b0, 16'd7,   16'd3,    32'd0);
      send_request(1'b0, 16'd5,   16'd9,    32'd16);
      send_request(1'b1, 16'd5,   16'd9,    32'd16);
   endtask

   // No idling at all: every request is held ready against busy.
   task automatic test_back_to_back();
      logic [15:0] first_step, last_step;
      max_gap = 0;
      for (int i = 0; i < 60; i++) begin
         pick_steps(first_step, last_step);
         send_request(i % 20 == 0, first_step, last_step, pick_bytes());
      end
      max_gap = 6;
   endtask

   // Allocation sets of random length, mostly short, some long enough to fill the table.
   // A few requests clear in mid-set or skip the clear at set start.
   task automatic test_random_sets();
      logic [15:0] first_step, last_step;
      int          set_len;
      bit          clear_first;
      while (requests_sent < TOTAL_REQUESTS) begin
         set_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                : $urandom_range(60, 72);
         max_gap = ($urandom_range(0, 7) == 0) ? 0 : 6;
         for (int i = 0; i < set_len; i++) begin
            pick_steps(first_step, last_step);
            if (i == 0)
               clear_first = $urandom_range(0, 19) != 0;
            else
               clear_first = $urandom_range(0, 39) == 0;
            send_request(clear_first, first_step, last_step, pick_bytes());
         end
         if ($urandom_range(0, 9) == 0)
            wait_for_drain();
      end
      max_gap = 6;
   endtask

   // Compare each response with the oldest expectation.
   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_valid) begin
         if (pending_placements.size() == 0) begin
            report_mismatch("response with no request waiting", rsp_placed_address, '0);
         end else begin
            want = pending_placements.pop_front();
            if (rsp_placed_address !== want.placed_address)
               report_mismatch("placed_address", rsp_placed_address, want.placed_address);
            if (rsp_peak_bytes !== want.peak_bytes)
               report_mismatch("peak_bytes", rsp_peak_bytes, want.peak_bytes);
            if (rsp_status !== want.status)
               report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no request or response for %0d cycles", QUIET_LIMIT);
         $display("[liveness_first_fit_allocator] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_table_full();
      test_back_to_back();
      test_random_sets();
      wait_for_drain();
      if (mismatch_count == 0)
         $display("[liveness_first_fit_allocator] OK");
      else
         $display("[liveness_first_fit_allocator] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/lffa_pkg.sv
hw/rtl/lffa_ram.sv
hw/rtl/lffa_scan_unit.sv
hw/rtl/liveness_first_fit_allocator.sv
hw/rtl/lffa_checker.sv
tb/liveness_first_fit_allocator_test.sv
